>>> sv/a2p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_pkg: shared types and constants of the atan2 approximation core
// Holds the fixed-point formats, the polynomial coefficients and the side-band
// record that travels with every word through the divider chain.
// ----------------------------------------------------------------------------
package a2p_pkg;

  // Ratio z = |num| / |den| in Q.15, 0..32768 (32768 is exactly 1.0).
  localparam int ZQ_W      = 16;
  localparam int Z_FRAC    = 15;
  // One quotient bit per divider cell.
  localparam int NUM_CELLS = ZQ_W;

  // Result angle, Q2.13.
  localparam int ANGLE_W   = 16;
  // Sum of offset and polynomial before saturation needs one more bit.
  localparam int SUM_W     = ANGLE_W + 1;

  // Cubic coefficients in Q.15: N1 and the magnitude of the negative N2.
  localparam logic [14:0] COEF_N1_Q15     = 15'd31863;
  localparam logic [12:0] COEF_N2_MAG_Q15 = 13'd6290;

  // Angle constants in Q.13.
  localparam logic signed [SUM_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [SUM_W-1:0] HALF_PI_Q13 = 17'sd12868;

  // Side-band information that selects the octant handling at the end.
  typedef struct packed {
    logic x_neg;   // x is negative
    logic y_neg;   // y is negative
    logic swap;    // |y| > |x|, so z = x / y
    logic x_zero;  // x is zero
    logic y_zero;  // y is zero
  } a2p_meta_t;

endpackage : a2p_pkg
`default_nettype wire

>>> sv/a2p_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_div_cell: one restoring-division cell
// Resolves one quotient bit, passes the shifted partial remainder, divisor,
// growing quotient and side-band record to the next cell each cycle en is high.
// ----------------------------------------------------------------------------
module a2p_div_cell #(
  parameter int W = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_v,
  input  wire logic [W:0]              in_rem,
  input  wire logic [W-1:0]            in_den,
  input  wire logic [a2p_pkg::ZQ_W-1:0] in_quo,
  input  wire a2p_pkg::a2p_meta_t      in_meta,
  output logic                         out_v,
  output logic [W:0]                   out_rem,
  output logic [W-1:0]                 out_den,
  output logic [a2p_pkg::ZQ_W-1:0]     out_quo,
  output a2p_pkg::a2p_meta_t           out_meta
);
  import a2p_pkg::*;

  logic                v_r;
  logic [W:0]          rem_r;
  logic [W-1:0]        den_r;
  logic [ZQ_W-1:0]     quo_r;
  a2p_meta_t           meta_r;

  logic                q_bit;
  logic [W:0]          diff;
  logic [W-1:0]        rem_left;

  // Trial subtraction; the remainder left over is always below the divisor.
  always_comb begin
    q_bit    = (in_rem >= {1'b0, in_den});
    diff     = in_rem - {1'b0, in_den};
    rem_left = q_bit ? diff[W-1:0] : in_rem[W-1:0];
  end

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  // Payload moves on whenever the chain advances.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= {rem_left, 1'b0};
      den_r  <= in_den;
      quo_r  <= {in_quo[ZQ_W-2:0], q_bit};
      meta_r <= in_meta;
    end
  end

  assign out_v    = v_r;
  assign out_rem  = rem_r;
  assign out_den  = den_r;
  assign out_quo  = quo_r;
  assign out_meta = meta_r;

endmodule : a2p_div_cell
`default_nettype wire

>>> sv/a2p_poly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a2p_poly: cubic evaluation and quadrant correction
// Four register stages: z^2, t = N1 - |N2|*z^2, t*z, then rounding, offset
// by 0, +-pi or +-pi/2, and saturation to +-pi.
// ----------------------------------------------------------------------------
module a2p_poly (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [a2p_pkg::ZQ_W-1:0]  in_zq,
  input  wire a2p_pkg::a2p_meta_t        in_meta,
  output logic                           out_v,
  output logic signed [a2p_pkg::ANGLE_W-1:0] out_angle
);
  import a2p_pkg::*;

  logic [3:0]              v_r;
  a2p_meta_t               meta1_r, meta2_r, meta3_r;
  logic [ZQ_W-1:0]         zq1_r, zq2_r;
  logic [15:0]             z2_r;
  logic [14:0]             t_r;
  logic [29:0]             prod_r;
  logic signed [ANGLE_W-1:0] angle_r;

  logic [31:0]             sq;
  logic [28:0]             n2z2;
  logic [14:0]             t_nxt;
  logic [29:0]             prod_nxt;
  logic [30:0]             rnd;
  logic [12:0]             p_mag;
  logic signed [SUM_W-1:0] p_s;
  logic signed [SUM_W-1:0] off;
  logic signed [SUM_W-1:0] sum;
  logic signed [ANGLE_W-1:0] angle_nxt;

  // Stage arithmetic; each stage holds at most one multiplication.
  always_comb begin
    sq       = in_zq * in_zq;
    n2z2     = 29'(z2_r) * 29'(COEF_N2_MAG_Q15);
    t_nxt    = COEF_N1_Q15 - {2'b00, n2z2[27:15]};
    prod_nxt = 30'(t_r) * 30'(zq2_r);
    rnd      = {1'b0, prod_r} + 31'd65536;
    p_mag    = rnd[29:17];
    p_s      = $signed({4'b0000, p_mag});
  end

  // Offset and sign of the polynomial by quadrant, then saturate.
  always_comb begin
    off = '0;
    sum = '0;
    if (meta3_r.x_zero) begin
      if (meta3_r.y_zero) begin
        sum = '0;
      end else begin
        sum = meta3_r.y_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      end
    end else if (!meta3_r.swap) begin
      if (meta3_r.x_neg) begin
        off = meta3_r.y_neg ? -PI_Q13 : PI_Q13;
      end
      sum = (meta3_r.x_neg ^ meta3_r.y_neg) ? off - p_s : off + p_s;
    end else begin
      off = meta3_r.y_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      sum = (meta3_r.x_neg ^ meta3_r.y_neg) ? off + p_s : off - p_s;
    end
    if (sum > PI_Q13) begin
      angle_nxt = ANGLE_W'(PI_Q13);
    end else if (sum < -PI_Q13) begin
      angle_nxt = ANGLE_W'(-PI_Q13);
    end else begin
      angle_nxt = sum[ANGLE_W-1:0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      zq1_r   <= in_zq;
      z2_r    <= sq[30:15];
      meta1_r <= in_meta;
      zq2_r   <= zq1_r;
      t_r     <= t_nxt;
      meta2_r <= meta1_r;
      prod_r  <= prod_nxt;
      meta3_r <= meta2_r;
      angle_r <= angle_nxt;
    end
  end

  assign out_v     = v_r[3];
  assign out_angle = angle_r;

endmodule : a2p_poly
`default_nettype wire

>>> sv/atan2_polynomial_approx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core: four-quadrant arctangent, cubic approximation
// Returns the angle of an (x, y) pair in radians, Q2.13, within +-pi.
// ----------------------------------------------------------------------------
// The core takes one (x, y) word per clock and returns one angle word per
// clock while the output is not stalled. Each word passes through one input
// register, a chain of 16 division cells that each resolve one bit of the
// ratio of the smaller magnitude to the larger, four polynomial stages and
// the output register. A skid register behind the output absorbs the word
// in flight when out_stall rises; in_stall is raised in the next cycle, while
// the skid holds it. Input ports are IN_WIDTH bits wide, two's complement.
module atan2_polynomial_approx_core #(
  parameter int IN_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [IN_WIDTH-1:0]           in_x_coord,
  input  wire logic signed [IN_WIDTH-1:0]           in_y_coord,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [a2p_pkg::ANGLE_W-1:0]        out_angle
);
  import a2p_pkg::*;

  localparam int W = IN_WIDTH;

  logic                 adv;
  logic                 x_neg, y_neg;
  logic [W-1:0]         ax, ay;
  a2p_meta_t            meta_in;

  logic                 v0_r;
  logic [W-1:0]         num_r, den_r;
  a2p_meta_t            meta0_r;

  logic                 c_v    [NUM_CELLS+1];
  logic [W:0]           c_rem  [NUM_CELLS+1];
  logic [W-1:0]         c_den  [NUM_CELLS+1];
  logic [ZQ_W-1:0]      c_quo  [NUM_CELLS+1];
  a2p_meta_t            c_meta [NUM_CELLS+1];

  logic                     p_v;
  logic signed [ANGLE_W-1:0] p_angle;

  logic                      out_v_r, out_v_nxt;
  logic signed [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic                      skid_v_r, skid_v_nxt;
  logic signed [ANGLE_W-1:0] skid_angle_r, skid_angle_nxt;

  // The whole pipeline moves while the skid register is empty.
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // Signs, magnitudes and the larger/smaller split of the incoming word.
  always_comb begin
    x_neg          = in_x_coord[W-1];
    y_neg          = in_y_coord[W-1];
    ax             = x_neg ? W'(-in_x_coord) : W'(in_x_coord);
    ay             = y_neg ? W'(-in_y_coord) : W'(in_y_coord);
    meta_in.x_neg  = x_neg;
    meta_in.y_neg  = y_neg;
    meta_in.swap   = (ay > ax);
    meta_in.x_zero = (ax == '0);
    meta_in.y_zero = (ay == '0);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= meta_in.swap ? ax : ay;
      den_r   <= meta_in.swap ? ay : ax;
      meta0_r <= meta_in;
    end
  end

  // Head of the division chain.
  assign c_v[0]    = v0_r;
  assign c_rem[0]  = {1'b0, num_r};
  assign c_den[0]  = den_r;
  assign c_quo[0]  = '0;
  assign c_meta[0] = meta0_r;

  // One cell per quotient bit, most significant first.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    a2p_div_cell #(
      .W(W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_v     (c_v[i]),
      .in_rem   (c_rem[i]),
      .in_den   (c_den[i]),
      .in_quo   (c_quo[i]),
      .in_meta  (c_meta[i]),
      .out_v    (c_v[i+1]),
      .out_rem  (c_rem[i+1]),
      .out_den  (c_den[i+1]),
      .out_quo  (c_quo[i+1]),
      .out_meta (c_meta[i+1])
    );
  end

  // Polynomial and quadrant correction.
  a2p_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (c_v[NUM_CELLS]),
    .in_zq     (c_quo[NUM_CELLS]),
    .in_meta   (c_meta[NUM_CELLS]),
    .out_v     (p_v),
    .out_angle (p_angle)
  );

  // Output register with a one-word skid stage.
  always_comb begin
    out_v_nxt      = out_v_r;
    out_angle_nxt  = out_angle_r;
    skid_v_nxt     = skid_v_r;
    skid_angle_nxt = skid_angle_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt     = 1'b1;
        out_angle_nxt = skid_angle_r;
        skid_v_nxt    = 1'b0;
      end else begin
        out_v_nxt     = p_v;
        out_angle_nxt = p_angle;
      end
    end else if (p_v && adv) begin
      skid_v_nxt     = 1'b1;
      skid_angle_nxt = p_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_angle_r  <= out_angle_nxt;
    skid_angle_r <= skid_angle_nxt;
  end

  assign out_valid = out_v_r;
  assign out_angle = out_angle_r;

endmodule : atan2_polynomial_approx_core
`default_nettype wire

>>> tb/atan2_polynomial_approx_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core_test: self-checking bench for the atan2 core
// Drives (x, y) words through the valid/stall input channel and checks every
// angle word against a bit-exact fixed-point prediction of the cubic arctangent.
// Both channels idle at random, the output is held off long enough to back the
// pipeline up, and the sender drains the core between phases.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_core_test;

  localparam int COORD_W    = 16;
  localparam int ANGLE_BITS = 16;
  localparam int CLK_HALF   = 5;
  localparam int CYCLE_CAP  = 200000;
  localparam int PIPE_DEPTH = 30;
  localparam int LONG_HOLD  = 150;
  localparam int IDLE_PCT   = 21;

  // Q.15 coefficients and Q.13 angle constants of the approximation.
  localparam logic [31:0] POLY_N1     = 32'd31863;
  localparam logic [31:0] POLY_N2_MAG = 32'd6290;
  localparam int          ANGLE_PI    = 25736;
  localparam int          ANGLE_HALF  = 12868;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  // One expected angle word together with the pair that caused it.
  typedef struct {
    coord_t x;
    coord_t y;
    angle_t angle;
  } angle_expect_t;

  // Scoreboard: predicts the angle of each accepted pair and checks results.
  class angle_scoreboard;
    angle_expect_t expected_angles[$];
    int unsigned   error_count;

    function new();
      error_count = 0;
    endfunction

    task report(string msg);
      error_count++;
      if (error_count <= 40) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endtask

    // Fixed-point arctangent: ratio of the smaller magnitude to the larger,
    // odd cubic on that ratio, then the octant offset and saturation.
    function automatic angle_t predict_angle(coord_t x, coord_t y);
      logic [16:0] mag_x, mag_y, num, den;
      logic [31:0] ratio, ratio_sq, coef;
      logic [47:0] prod;
      logic        swap, neg_ratio;
      int          poly, offset, sum;
      mag_x = x[COORD_W-1] ? 17'h10000 - {1'b0, x} : {1'b0, x};
      mag_y = y[COORD_W-1] ? 17'h10000 - {1'b0, y} : {1'b0, y};
      sum = 0;
      if (mag_x != 0) begin
        swap      = mag_y > mag_x;
        num       = swap ? mag_x : mag_y;
        den       = swap ? mag_y : mag_x;
        ratio     = ({15'd0, num} << 15) / {15'd0, den};
        ratio_sq  = (ratio * ratio) >> 15;
        coef      = POLY_N1 - ((POLY_N2_MAG * ratio_sq) >> 15);
        prod      = 48'(coef) * 48'(ratio) + 48'd65536;
        poly      = int'(prod >> 17);
        neg_ratio = x[COORD_W-1] ^ y[COORD_W-1];
        if (!swap) begin
          offset = 0;
          if (x[COORD_W-1]) begin
            offset = y[COORD_W-1] ? -ANGLE_PI : ANGLE_PI;
          end
          sum = neg_ratio ? offset - poly : offset + poly;
        end else begin
          offset = y[COORD_W-1] ? -ANGLE_HALF : ANGLE_HALF;
          sum = neg_ratio ? offset + poly : offset - poly;
        end
      end else if (mag_y != 0) begin
        sum = y[COORD_W-1] ? -ANGLE_HALF : ANGLE_HALF;
      end
      if (sum > ANGLE_PI) begin
        sum = ANGLE_PI;
      end
      if (sum < -ANGLE_PI) begin
        sum = -ANGLE_PI;
      end
      return angle_t'(sum);
    endfunction

    function void note_pair(coord_t x, coord_t y);
      angle_expect_t item;
      item.x     = x;
      item.y     = y;
      item.angle = predict_angle(x, y);
      expected_angles.push_back(item);
    endfunction

    task check_angle(angle_t got);
      angle_expect_t item;
      if (expected_angles.size() == 0) begin
        report($sformatf("angle word %0d with no pair outstanding", got));
      end else begin
        item = expected_angles.pop_front();
        if (got !== item.angle) begin
          report($sformatf("x=%0d y=%0d angle got %0d expected %0d",
                           item.x, item.y, got, item.angle));
        end
      end
    endtask

    function int unsigned pending_count();
      return expected_angles.size();
    endfunction
  endclass

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  coord_t in_x_coord = '0;
  coord_t in_y_coord = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  angle_t out_angle;

  angle_scoreboard scoreboard = new();

  // Idling controls for both channels and long hold-off requests.
  bit          in_idle_en    = 1'b1;
  bit          out_idle_en   = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  atan2_polynomial_approx_core #(
    .IN_WIDTH(COORD_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_angle (out_angle)
  );

  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Cycle counter with a hard limit in case the core hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each accepted word, then choose the next stall value.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        scoreboard.check_angle(out_angle);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= out_idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one pair until the core takes it, then maybe idle a few cycles.
  task send_pair(coord_t x, coord_t y);
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    scoreboard.note_pair(x, y);
    while (in_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task wait_for_drain();
    in_valid <= 1'b0;
    while (scoreboard.pending_count() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random pair, weighted toward zeros, extremes and near-equal magnitudes.
  function automatic void make_random_pair(output coord_t x, output coord_t y);
    int unsigned kind;
    kind = $urandom_range(9);
    x = coord_t'($urandom());
    y = coord_t'($urandom());
    case (kind)
      5: begin
        x = coord_t'($urandom_range(15));
        y = coord_t'($urandom_range(15));
        if ($urandom_range(1)) x = -x;
        if ($urandom_range(1)) y = -y;
      end
      6: begin
        y = $urandom_range(1) ? x : -x;
      end
      7: begin
        if ($urandom_range(1)) x = '0;
        else y = '0;
      end
      8: begin
        x = $urandom_range(1) ? coord_t'(16'h8000) : coord_t'(16'h7fff);
        if ($urandom_range(1)) begin
          {x, y} = {y, x};
        end
      end
      9: begin
        y = x + coord_t'($urandom_range(4)) - coord_t'(2);
        if ($urandom_range(1)) y = -y;
      end
      default: begin
      end
    endcase
  endfunction

  task send_random(int unsigned count);
    coord_t x, y;
    repeat (count) begin
      make_random_pair(x, y);
      send_pair(x, y);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zeros, axes, equal magnitudes, most negative values, octants.
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd5, 16'sd0);
    send_pair(16'sd9, 16'sd0);
    send_pair(16'sd0, 16'sd7);
    send_pair(16'sd0, -16'sd7);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(coord_t'(16'h8000), coord_t'(16'h8000));
    send_pair(coord_t'(16'h8000), 16'sd32767);
    send_pair(16'sd32767, coord_t'(16'h8000));
    send_pair(coord_t'(16'h8000), 16'sd0);
    send_pair(16'sd0, coord_t'(16'h8000));
    send_pair(16'sd1, coord_t'(16'h8000));
    send_pair(16'sd100, 16'sd100);
    send_pair(-16'sd100, 16'sd100);
    send_pair(-16'sd100, -16'sd100);
    send_pair(16'sd100, -16'sd100);
    send_pair(16'sd3, 16'sd1);
    send_pair(16'sd1, 16'sd3);
    send_pair(-16'sd1, 16'sd3);
    send_pair(-16'sd3, -16'sd1);
    send_pair(16'sd32767, 16'sd1);
    send_pair(16'sd1, 16'sd32767);
    send_pair(coord_t'(16'h8000), 16'sd1);
    send_pair(-16'sd1, -16'sd32767);
    wait_for_drain();

    // Back-pressure: hold the output off while words keep coming.
    hold_requests++;
    in_idle_en = 1'b0;
    send_random(60);
    in_idle_en = 1'b1;

    send_random(400);

    // Stretch with no idling on either side.
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_random(200);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    wait_for_drain();

    send_random(240);
    wait_for_drain();
    repeat (PIPE_DEPTH) @(posedge clk);

    if (scoreboard.pending_count() != 0) begin
      scoreboard.report($sformatf("%0d angle words never arrived",
                                  scoreboard.pending_count()));
    end
    if (scoreboard.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
